// ===== hw/rtl/sbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants of the stereo bar meter with peak hold.
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int SEGMENTS_DEFAULT   = 9;
   localparam int LEVEL_BITS_DEFAULT = 10;
   localparam int TIMER_BITS_DEFAULT = 8;

   localparam int BAR_COUNT      = 2;
   localparam int THR_LOW_COUNT  = 6;
   localparam int THR_LOW_BITS   = 60;
   localparam int THR_HIGH_BITS  = 40;
   localparam int RED_MASK_BITS  = 9;
   localparam int FRAME_BITS     = 8;
   localparam int CSR_DATA_BITS  = 60;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PEAK_BITS      = 4;

   localparam logic [PEAK_BITS-1:0] PEAK_NONE = '1;

   localparam logic [FRAME_BITS-1:0] HOLD_FRAMES_RESET = 8'd30;
   localparam logic [FRAME_BITS-1:0] FALL_FRAMES_RESET = 8'd5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MODE            = 3'd0,
      REG_THRESHOLDS_LOW  = 3'd1,
      REG_THRESHOLDS_HIGH = 3'd2,
      REG_RED_MASK        = 3'd3,
      REG_HOLD_FRAMES     = 3'd4,
      REG_FALL_FRAMES     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      COLOR_OFF   = 2'd0,
      COLOR_GREEN = 2'd1,
      COLOR_RED   = 2'd2
   } color_type;

endpackage

// ===== hw/rtl/stereo_bar_meter_peak_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_bar_meter_peak_hold
// Two-bar level meter: threshold compare, colored bars or peak-hold marker.
// ----------------------------------------------------------------------------
// Each request carries one level per bar; each yields one frame of segment
// colors per bar. The block takes a request in every cycle: a request is
// registered, evaluated against the thresholds and the stored peak markers
// in one pass, and the frame moves into the result register as soon as that
// register is empty or its frame is taken. The result register lets a new
// request enter while a frame waits to be taken; with both registers full
// the request side stalls until the frame is taken. Writing any of the six
// registers clears both peak markers and their timers; the user must write
// registers only while no request is in flight, the block does not enforce it.
// ----------------------------------------------------------------------------
module stereo_bar_meter_peak_hold
   import sbm_pkg::*;
#(
   parameter int SEGMENTS   = SEGMENTS_DEFAULT,
   parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT,
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [LEVEL_BITS-1:0]     req_level_a,
   input  logic [LEVEL_BITS-1:0]     req_level_b,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2*SEGMENTS-1:0]     rsp_bar_a,
   output logic [2*SEGMENTS-1:0]     rsp_bar_b,

   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int EXT_BITS = 64 + LEVEL_BITS;

   // configuration
   logic                     mode_ff;
   logic [THR_LOW_BITS-1:0]  thr_low_ff;
   logic [THR_HIGH_BITS-1:0] thr_high_ff;
   logic [RED_MASK_BITS-1:0] red_mask_ff;
   logic [FRAME_BITS-1:0]    hold_frames_ff;
   logic [FRAME_BITS-1:0]    fall_frames_ff;
   logic                     peak_clear;

   // pipeline control and payload
   logic                  s1_valid_ff, s1_valid_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  req_take, advance;
   logic [LEVEL_BITS-1:0] level_ff [BAR_COUNT];
   logic [2*SEGMENTS-1:0] bar_ff   [BAR_COUNT];
   logic [2*SEGMENTS-1:0] bar_in   [BAR_COUNT];

   // peak state
   logic [PEAK_BITS-1:0]  peak_ff  [BAR_COUNT];
   logic [PEAK_BITS-1:0]  peak_in  [BAR_COUNT];
   logic [TIMER_BITS-1:0] timer_ff [BAR_COUNT];
   logic [TIMER_BITS-1:0] timer_in [BAR_COUNT];

   logic [LEVEL_BITS-1:0] thr [SEGMENTS+1];
   logic [EXT_BITS-1:0]   thr_low_ext, thr_high_ext;
   logic [SEGMENTS-1:0]   red_ext;
   logic [15:0]           hold_wide, fall_wide;
   logic [TIMER_BITS-1:0] hold_t, fall_t;

   // -------------------------------------------------------------------------
   // configuration port
   // -------------------------------------------------------------------------
   always_comb begin
      unique case (csr_index)
         REG_MODE, REG_THRESHOLDS_LOW, REG_THRESHOLDS_HIGH,
         REG_RED_MASK, REG_HOLD_FRAMES, REG_FALL_FRAMES: peak_clear = csr_write_en;
         default: peak_clear = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b1;
         thr_low_ff     <= '0;
         thr_high_ff    <= '0;
         red_mask_ff    <= '0;
         hold_frames_ff <= HOLD_FRAMES_RESET;
         fall_frames_ff <= FALL_FRAMES_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MODE:            mode_ff        <= csr_data[0];
            REG_THRESHOLDS_LOW:  thr_low_ff     <= csr_data[THR_LOW_BITS-1:0];
            REG_THRESHOLDS_HIGH: thr_high_ff    <= csr_data[THR_HIGH_BITS-1:0];
            REG_RED_MASK:        red_mask_ff    <= csr_data[RED_MASK_BITS-1:0];
            REG_HOLD_FRAMES:     hold_frames_ff <= csr_data[FRAME_BITS-1:0];
            REG_FALL_FRAMES:     fall_frames_ff <= csr_data[FRAME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // threshold fields beyond a register's bits read as zero
   assign thr_low_ext  = {{(EXT_BITS-THR_LOW_BITS){1'b0}}, thr_low_ff};
   assign thr_high_ext = {{(EXT_BITS-THR_HIGH_BITS){1'b0}}, thr_high_ff};

   for (genvar i = 0; i <= SEGMENTS; i++) begin : g_thr
      localparam int POS = (i < THR_LOW_COUNT) ? i * LEVEL_BITS
                                               : (i - THR_LOW_COUNT) * LEVEL_BITS;
      if (POS >= 64) begin : g_zero
         assign thr[i] = '0;
      end else if (i < THR_LOW_COUNT) begin : g_low
         assign thr[i] = thr_low_ext[POS +: LEVEL_BITS];
      end else begin : g_high
         assign thr[i] = thr_high_ext[POS +: LEVEL_BITS];
      end
   end

   for (genvar t = 0; t < SEGMENTS; t++) begin : g_red
      if (t < RED_MASK_BITS) begin : g_bit
         assign red_ext[t] = red_mask_ff[t];
      end else begin : g_none
         assign red_ext[t] = 1'b0;
      end
   end

   assign hold_wide = {{(16-FRAME_BITS){1'b0}}, hold_frames_ff};
   assign fall_wide = {{(16-FRAME_BITS){1'b0}}, fall_frames_ff};
   assign hold_t    = hold_wide[TIMER_BITS-1:0];
   assign fall_t    = fall_wide[TIMER_BITS-1:0];

   // -------------------------------------------------------------------------
   // handshake
   // -------------------------------------------------------------------------
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         level_ff[0] <= req_level_a;
         level_ff[1] <= req_level_b;
      end
      if (advance) begin
         bar_ff[0] <= bar_in[0];
         bar_ff[1] <= bar_in[1];
      end
   end

   // -------------------------------------------------------------------------
   // per-bar evaluation
   // -------------------------------------------------------------------------
   for (genvar b = 0; b < BAR_COUNT; b++) begin : g_bar
      logic [SEGMENTS-1:0]   lit, hit;
      logic                  no_peak, cap;
      logic [PEAK_BITS-1:0]  cap_pk, pk_mid, pk_fall;
      logic [TIMER_BITS-1:0] tm_mid, tm_fall;
      logic [2*SEGMENTS-1:0] bar_norm, bar_hold;

      always_comb begin
         for (int t = 0; t < SEGMENTS; t++) begin
            lit[t] = level_ff[b] >= thr[t];
            hit[t] = lit[t] && (level_ff[b] < thr[t+1]);
         end
      end

      assign no_peak = peak_ff[b] == PEAK_NONE;

      // highest segment whose band holds the level, at or above the old peak
      always_comb begin
         cap    = 1'b0;
         cap_pk = peak_ff[b];
         for (int t = 0; t < SEGMENTS; t++) begin
            if (hit[t] && (no_peak || PEAK_BITS'(t) >= peak_ff[b])) begin
               cap    = 1'b1;
               cap_pk = PEAK_BITS'(t);
            end
         end
      end

      assign pk_mid = cap ? cap_pk : peak_ff[b];
      assign tm_mid = cap ? hold_t : timer_ff[b];

      always_comb begin
         for (int t = 0; t < SEGMENTS; t++) begin
            bar_norm[2*t +: 2] = lit[t] ? (red_ext[t] ? COLOR_RED : COLOR_GREEN) : COLOR_OFF;
            if (pk_mid != PEAK_NONE && pk_mid == PEAK_BITS'(t)) begin
               bar_hold[2*t +: 2] = COLOR_RED;
            end else begin
               bar_hold[2*t +: 2] = lit[t] ? COLOR_GREEN : COLOR_OFF;
            end
         end
      end

      // marker fall, then timer count-down
      always_comb begin
         pk_fall = pk_mid;
         tm_fall = tm_mid;
         if (tm_mid == '0 && pk_mid != PEAK_NONE) begin
            tm_fall = fall_t;
            pk_fall = (pk_mid == '0) ? PEAK_NONE : pk_mid - 1'b1;
         end
         if (tm_fall != '0) begin
            tm_fall = tm_fall - 1'b1;
         end
      end

      assign bar_in[b] = mode_ff ? bar_norm : bar_hold;

      always_comb begin
         peak_in[b]  = peak_ff[b];
         timer_in[b] = timer_ff[b];
         if (peak_clear) begin
            peak_in[b]  = PEAK_NONE;
            timer_in[b] = '0;
         end else if (advance && !mode_ff) begin
            peak_in[b]  = pk_fall;
            timer_in[b] = tm_fall;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            peak_ff[b]  <= PEAK_NONE;
            timer_ff[b] <= '0;
         end else begin
            peak_ff[b]  <= peak_in[b];
            timer_ff[b] <= timer_in[b];
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_bar_a = bar_ff[0];
   assign rsp_bar_b = bar_ff[1];

   // -------------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------------
   logic bad_code;

   always_comb begin
      bad_code = 1'b0;
      for (int t = 0; t < SEGMENTS; t++) begin
         bad_code = bad_code || (rsp_bar_a[2*t +: 2] == 2'b11)
                             || (rsp_bar_b[2*t +: 2] == 2'b11);
      end
   end

   a_clear_peaks: assert property (@(posedge clock) disable iff (reset)
      peak_clear |=> (peak_ff[0] == PEAK_NONE && peak_ff[1] == PEAK_NONE &&
                      timer_ff[0] == '0 && timer_ff[1] == '0))
      else $error("peak state not cleared after register write");

   a_normal_keeps_peaks: assert property (@(posedge clock) disable iff (reset)
      (mode_ff && !csr_write_en) |=> ($stable(peak_ff[0]) && $stable(peak_ff[1]) &&
                                      $stable(timer_ff[0]) && $stable(timer_ff[1])))
      else $error("peak state changed in normal mode");

   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      (peak_ff[0] == PEAK_NONE || {1'b0, peak_ff[0]} < (PEAK_BITS+1)'(SEGMENTS)) &&
      (peak_ff[1] == PEAK_NONE || {1'b0, peak_ff[1]} < (PEAK_BITS+1)'(SEGMENTS)))
      else $error("peak marker outside the bar");

   a_no_bad_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !bad_code)
      else $error("segment color code 3 on output");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("request stalled with result register empty");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo bar meter with peak hold.
// ----------------------------------------------------------------------------
// Levels go in on the request channel and frames come back on the result
// channel. A local model of both bars, their peak markers and timers predicts
// each frame. Directed tests cover reset values, colored bars, peak capture,
// hold, fall, the threshold cap and spare register indexes. One long receiver
// stall follows, then random phases with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
   import sbm_pkg::*;

   localparam int LVL_W         = LEVEL_BITS_DEFAULT;
   localparam int SEGS          = SEGMENTS_DEFAULT;
   localparam int BAR_W         = 2 * SEGMENTS_DEFAULT;
   localparam int THR_COUNT     = SEGMENTS_DEFAULT + 1;
   localparam int RSP_SETTLE    = 4;
   localparam int STALL_LIMIT   = 1000;
   localparam int PRESSURE_HOLD = 60;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [BAR_W-1:0] bar_a;
      logic [BAR_W-1:0] bar_b;
   } frame_type;

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   logic [LVL_W-1:0]          req_level_a  = '0;
   logic [LVL_W-1:0]          req_level_b  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   logic [BAR_W-1:0]          rsp_bar_a;
   logic [BAR_W-1:0]          rsp_bar_b;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index    = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data     = '0;

   // model copy of the registers
   logic                     cfg_mode;
   logic [THR_LOW_BITS-1:0]  cfg_thr_lo;
   logic [THR_HIGH_BITS-1:0] cfg_thr_hi;
   logic [RED_MASK_BITS-1:0] cfg_red;
   logic [FRAME_BITS-1:0]    cfg_hold;
   logic [FRAME_BITS-1:0]    cfg_fall;

   // model copy of the peak markers
   logic [PEAK_BITS-1:0]     marker_seg [BAR_COUNT];
   logic [FRAME_BITS-1:0]    marker_count [BAR_COUNT];

   logic [LVL_W-1:0] thr_table [THR_COUNT];
   logic [LVL_W-1:0] walk_a = '0;
   logic [LVL_W-1:0] walk_b = '0;

   frame_type pending_frames [$];
   int     mismatch_count     = 0;
   int     sender_idle_pct    = 0;
   int     receiver_stall_pct = 0;
   int     hold_off_left      = 0;
   int     quiet_cycles       = 0;

   stereo_bar_meter_peak_hold dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_level_a  (req_level_a),
      .req_level_b  (req_level_b),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_bar_a    (rsp_bar_a),
      .rsp_bar_b    (rsp_bar_b),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [CSR_DATA_BITS-1:0] rand60();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[CSR_DATA_BITS-1:0];
   endfunction

   function automatic logic [LVL_W-1:0] thr_at(input int i);
      if (i < THR_LOW_COUNT) return cfg_thr_lo[i*LVL_W +: LVL_W];
      return cfg_thr_hi[(i-THR_LOW_COUNT)*LVL_W +: LVL_W];
   endfunction

   // one bar of the frame; in peak-hold mode this also moves the marker
   function automatic logic [BAR_W-1:0] bar_colors(input logic [LVL_W-1:0] level,
                                                   input int b);
      logic [BAR_W-1:0] bar;
      int t;
      bar = '0;
      if (cfg_mode) begin
         for (t = 0; t < SEGS; t++)
            if (level >= thr_at(t)) bar[2*t +: 2] = cfg_red[t] ? COLOR_RED : COLOR_GREEN;
         return bar;
      end
      for (t = 0; t < SEGS; t++) begin
         if (level >= thr_at(t)) begin
            bar[2*t +: 2] = COLOR_GREEN;
            if (level < thr_at(t + 1) &&
                (marker_seg[b] == PEAK_NONE || t >= marker_seg[b])) begin
               marker_seg[b]   = PEAK_BITS'(t);
               marker_count[b] = cfg_hold;
            end
         end
      end
      // marker is red even over an unlit segment
      if (marker_seg[b] != PEAK_NONE && marker_seg[b] < SEGS)
         bar[2*marker_seg[b] +: 2] = COLOR_RED;
      if (marker_count[b] == 0 && marker_seg[b] != PEAK_NONE) begin
         marker_count[b] = cfg_fall;
         marker_seg[b]   = (marker_seg[b] == 0) ? PEAK_NONE : marker_seg[b] - 1'b1;
      end
      if (marker_count[b] != 0) marker_count[b] = marker_count[b] - 1'b1;
      return bar;
   endfunction

   function automatic frame_type meter_frame(input logic [LVL_W-1:0] level_a,
                                             input logic [LVL_W-1:0] level_b);
      frame_type f;
      f.bar_a = bar_colors(level_a, 0);
      f.bar_b = bar_colors(level_b, 1);
      return f;
   endfunction

   // random walk with jumps and rail hits, so peaks rise and decay
   function automatic logic [LVL_W-1:0] next_level(input logic [LVL_W-1:0] prev);
      int roll;
      int v;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 10) return '1;
      if (roll < 30) return LVL_W'($urandom_range(0, 1023));
      v = int'(prev) + $urandom_range(0, 300) - 150;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[LVL_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // bits above the register width carry junk, the block must drop them
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] keep;
      logic known;
      known = 1'b1;
      keep  = '1;
      case (idx)
         REG_MODE: begin
            keep = 60'h1;
            cfg_mode = value[0];
         end
         REG_THRESHOLDS_LOW: begin
            cfg_thr_lo = value[THR_LOW_BITS-1:0];
         end
         REG_THRESHOLDS_HIGH: begin
            keep = 60'hFF_FFFF_FFFF;
            cfg_thr_hi = value[THR_HIGH_BITS-1:0];
         end
         REG_RED_MASK: begin
            keep = 60'h1FF;
            cfg_red = value[RED_MASK_BITS-1:0];
         end
         REG_HOLD_FRAMES: begin
            keep = 60'hFF;
            cfg_hold = value[FRAME_BITS-1:0];
         end
         REG_FALL_FRAMES: begin
            keep = 60'hFF;
            cfg_fall = value[FRAME_BITS-1:0];
         end
         default: known = 1'b0;
      endcase
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= (value & keep) | (rand60() & ~keep);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (known) begin
         marker_seg[0]   = PEAK_NONE;
         marker_seg[1]   = PEAK_NONE;
         marker_count[0] = '0;
         marker_count[1] = '0;
      end
   endtask

   task automatic write_thresholds();
      logic [THR_LOW_BITS-1:0]  lo;
      logic [THR_HIGH_BITS-1:0] hi;
      int i;
      for (i = 0; i < THR_LOW_COUNT; i++) lo[i*LVL_W +: LVL_W] = thr_table[i];
      for (i = THR_LOW_COUNT; i < THR_COUNT; i++)
         hi[(i-THR_LOW_COUNT)*LVL_W +: LVL_W] = thr_table[i];
      write_reg(REG_THRESHOLDS_LOW, lo);
      write_reg(REG_THRESHOLDS_HIGH, CSR_DATA_BITS'(hi));
   endtask

   task automatic send_levels(input logic [LVL_W-1:0] level_a,
                              input logic [LVL_W-1:0] level_b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_level_a <= level_a;
      req_level_b <= level_b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_frames.push_back(meter_frame(level_a, level_b));
   endtask

   // sender goes quiet until every frame is back
   task automatic wait_for_frames();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (RSP_SETTLE) @(posedge clock);
   endtask

   task automatic load_phase_config(input int phase);
      int i;
      int base;
      base = 0;
      for (i = 0; i < THR_COUNT; i++) begin
         if (phase == 0) begin
            thr_table[i] = '0;
         end else if (phase == 7) begin
            thr_table[i] = '1;
         end else if (phase % 2 == 1) begin
            thr_table[i] = LVL_W'($urandom_range(0, 1023));
         end else begin
            base = base + $urandom_range(0, 180);
            thr_table[i] = (base > 1023) ? 10'd1023 : base[LVL_W-1:0];
         end
      end
      write_reg(REG_MODE, CSR_DATA_BITS'((phase == 1 || phase == 6) ? 1 : 0));
      write_thresholds();
      write_reg(REG_RED_MASK, CSR_DATA_BITS'((phase == 1) ? 511 : $urandom_range(0, 511)));
      write_reg(REG_HOLD_FRAMES, CSR_DATA_BITS'((phase == 2) ? 0 : (phase == 3) ? 255 :
                                                $urandom_range(0, 6)));
      write_reg(REG_FALL_FRAMES, CSR_DATA_BITS'((phase == 2) ? 0 : (phase == 4) ? 255 :
                                                $urandom_range(0, 4)));
   endtask

   task automatic test_reset_defaults();
      send_levels(10'd0, 10'd0);
      send_levels(10'd1023, 10'd1023);
      wait_for_frames();
   endtask

   task automatic test_normal_bars();
      int i;
      for (i = 0; i < THR_COUNT; i++) thr_table[i] = LVL_W'(100 * (i + 1));
      write_thresholds();
      write_reg(REG_RED_MASK, CSR_DATA_BITS'(9'h1C0));
      write_reg(REG_MODE, CSR_DATA_BITS'(1));
      send_levels(10'd0, 10'd99);
      send_levels(10'd100, 10'd1023);
      send_levels(10'd550, 10'd999);
      wait_for_frames();
      write_reg(REG_RED_MASK, CSR_DATA_BITS'(9'h1FF));
      send_levels(10'd1023, 10'd450);
      wait_for_frames();
      write_reg(REG_RED_MASK, CSR_DATA_BITS'(9'h000));
      send_levels(10'd0, 10'd1023);
      wait_for_frames();
   endtask

   task automatic test_peak_hold();
      int n;
      // reset hold and fall still in force here
      write_reg(REG_MODE, CSR_DATA_BITS'(0));
      send_levels(10'd250, 10'd150);
      send_levels(10'd0, 10'd0);
      wait_for_frames();
      write_reg(REG_HOLD_FRAMES, CSR_DATA_BITS'(2));
      write_reg(REG_FALL_FRAMES, CSR_DATA_BITS'(1));
      send_levels(10'd250, 10'd150);
      for (n = 0; n < 5; n++) send_levels(10'd0, 10'd0);
      // top segment capped by the last threshold
      send_levels(10'd950, 10'd1023);
      wait_for_frames();
      // non-monotone table, several segments match and the highest wins
      thr_table = '{10'd300, 10'd100, 10'd500, 10'd200, 10'd0,
                    10'd700, 10'd50, 10'd900, 10'd20, 10'd800};
      write_thresholds();
      send_levels(10'd600, 10'd250);
      send_levels(10'd60, 10'd1023);
      wait_for_frames();
      write_reg(REG_HOLD_FRAMES, CSR_DATA_BITS'(0));
      write_reg(REG_FALL_FRAMES, CSR_DATA_BITS'(0));
      send_levels(10'd350, 10'd850);
      send_levels(10'd0, 10'd0);
      send_levels(10'd0, 10'd0);
      wait_for_frames();
   endtask

   task automatic test_spare_registers();
      int i;
      for (i = 0; i < THR_COUNT; i++) thr_table[i] = LVL_W'(100 * (i + 1));
      write_thresholds();
      write_reg(REG_HOLD_FRAMES, CSR_DATA_BITS'(255));
      send_levels(10'd950, 10'd650);
      wait_for_frames();
      // spare indexes must leave the markers alone
      write_reg(REG_SPARE_LO, rand60());
      write_reg(REG_SPARE_HI, rand60());
      send_levels(10'd0, 10'd0);
      wait_for_frames();
      write_reg(REG_FALL_FRAMES, CSR_DATA_BITS'(5));
      send_levels(10'd0, 10'd0);
      wait_for_frames();
   endtask

   // receiver holds off long enough for the block to fill and stall requests
   task automatic test_backpressure();
      int n;
      hold_off_left = PRESSURE_HOLD;
      for (n = 0; n < 12; n++) begin
         walk_a = next_level(walk_a);
         walk_b = next_level(walk_b);
         send_levels(walk_a, walk_b);
      end
      wait_for_frames();
   endtask

   task automatic test_random_frames();
      int phase;
      int n;
      for (phase = 0; phase < 8; phase++) begin
         load_phase_config(phase);
         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 49;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 49;
            end
            default: begin
               sender_idle_pct = 35;
               receiver_stall_pct = 35;
            end
         endcase
         for (n = 0; n < 100; n++) begin
            if (n == 50) wait_for_frames();
            walk_a = next_level(walk_a);
            walk_b = next_level(walk_b);
            send_levels(walk_a, walk_b);
         end
         wait_for_frames();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            report_mismatch($sformatf("frame with none expected: a=%h b=%h",
                                      rsp_bar_a, rsp_bar_b));
         end else begin
            want = pending_frames.pop_front();
            if (rsp_bar_a !== want.bar_a)
               report_mismatch($sformatf("bar_a got %h expected %h", rsp_bar_a, want.bar_a));
            if (rsp_bar_b !== want.bar_b)
               report_mismatch($sformatf("bar_b got %h expected %h", rsp_bar_b, want.bar_b));
         end
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      cfg_mode        = 1'b1;
      cfg_thr_lo      = '0;
      cfg_thr_hi      = '0;
      cfg_red         = '0;
      cfg_hold        = HOLD_FRAMES_RESET;
      cfg_fall        = FALL_FRAMES_RESET;
      marker_seg[0]   = PEAK_NONE;
      marker_seg[1]   = PEAK_NONE;
      marker_count[0] = '0;
      marker_count[1] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_normal_bars();
      test_peak_hold();
      test_spare_registers();
      test_backpressure();
      test_random_frames();
      wait_for_frames();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sbm_pkg.sv
hw/rtl/stereo_bar_meter_peak_hold.sv
tb/sv/tb.sv
